[rtl/rcst_pkg.sv]
// Shared constants and codes for the range count segment tree block.
// No dependencies; imported by the top level and by its port checker.
package rcst_pkg;

  localparam int LEAVES     = 8192;
  localparam int EMPLOYEES  = 4096;

  localparam int RANK_W     = 13;
  localparam int CNT_W      = 13;
  localparam int EMP_W      = 12;
  localparam int LC_W       = 14;
  localparam int REQ_W      = 2;

  localparam int NODE_DEPTH = 2 * LEAVES;
  localparam int NODE_AW    = $clog2(NODE_DEPTH);
  localparam int BOUND_W    = NODE_AW + 1;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 16;

  localparam logic [LC_W-1:0] LEAF_COUNT_RST = LC_W'(8192);

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD   = 2'd0,
    REQ_CHANGE = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

endpackage

[rtl/range_count_segment_tree.sv]
// Range count segment tree: top level with node memory, rank memory and sequencer.
// Depends on rcst_pkg.
//
//  Channel  | Signals                         | Carries
//  ---------+---------------------------------+----------------------------------------
//  s_axis   | tvalid/tready/tdata/tuser       | request item: kind, employee, ranks
//  m_axis   | tvalid/tready/tdata/tuser       | result item: count, range error flag
//  cfg      | cfg_we_i/cfg_wdata_i            | leaf_count register
//
// A load walks the new leaf up to the root, a change walks the old leaf, when it is in range, and then
// the new one, and a query walks both bounds up the tree level by level; the single node memory read
// port, one sibling or bound node per cycle, sets the pace of these walks.
// After reset a clearing pass writes zero to all 16384 nodes, one per cycle, with
// s_axis_tready_o low. Items are taken one at a time; a result waits in the output
// register and stalls the sequencer only when another result is due before it is taken.
module range_count_segment_tree
  import rcst_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [LC_W-1:0]       cfg_wdata_i,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // employee_index, new_rank, low_rank, high_rank, zero padding
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // req_type
  input  logic [REQ_W-1:0]      s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // count, zero padding
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // range_error
  output logic [0:0]            m_axis_tuser_o
);

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_DEC    = 9'b000000100,
    S_CHG    = 9'b000001000,
    S_RDLEAF = 9'b000010000,
    S_LEAF   = 9'b000100000,
    S_UP     = 9'b001000000,
    S_QL     = 9'b010000000,
    S_QR     = 9'b100000000
  } state_e;

  localparam logic [CNT_W-1:0] DELTA_INC = CNT_W'(1);
  localparam logic [CNT_W-1:0] DELTA_DEC = '1;

  state_e state_q, state_d;

  logic [LC_W-1:0]    leaf_count_q;
  logic [NODE_AW-1:0] clr_q, clr_d;
  logic [NODE_AW-1:0] p_q, p_d;
  logic [CNT_W-1:0]   cur_q, cur_d;
  logic [CNT_W-1:0]   delta_q, delta_d;
  logic               second_q, second_d;
  logic [BOUND_W-1:0] l_q, l_d, r_q, r_d;
  logic [CNT_W-1:0]   sum_q, sum_d;
  logic               pend_q, pend_d;

  logic [REQ_W-1:0]   req_q;
  logic [EMP_W-1:0]   emp_q;
  logic [RANK_W-1:0]  nr_q, lo_q, hi_q;

  logic               out_valid_q;
  logic [CNT_W-1:0]   out_cnt_q, out_cnt_d;
  logic               out_err_q, out_err_d;
  logic               out_load;
  logic               out_free;

  logic [CNT_W-1:0]   node_mem [NODE_DEPTH];
  logic [CNT_W-1:0]   node_rdata_q;
  logic               node_we;
  logic [NODE_AW-1:0] node_waddr, node_raddr;
  logic [CNT_W-1:0]   node_wdata;

  logic [RANK_W-1:0]  emp_mem [EMPLOYEES];
  logic [RANK_W-1:0]  emp_rdata_q;
  logic               emp_we;

  logic [LC_W-1:0]    n_eff;
  logic               in_accept;
  logic               lo_ok, hi_ok, nr_ok, old_ok, emp_ok;
  logic [NODE_AW-1:0] nr_leaf, old_leaf, q_up;
  logic [CNT_W-1:0]   acc, leaf_sum, parent_sum;
  logic [BOUND_W-1:0] r_dec;
  logic               walk_done;

  assign n_eff     = (leaf_count_q > LC_W'(LEAVES)) ? LC_W'(LEAVES) : leaf_count_q;
  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free  = !out_valid_q || m_axis_tready_i;

  assign lo_ok    = LC_W'(lo_q) < n_eff;
  assign hi_ok    = LC_W'(hi_q) < n_eff;
  assign nr_ok    = LC_W'(nr_q) < n_eff;
  assign old_ok   = LC_W'(emp_rdata_q) < n_eff;
  assign emp_ok   = (EMP_W + 1)'(emp_q) < (EMP_W + 1)'(EMPLOYEES);
  assign nr_leaf  = NODE_AW'(nr_q) + NODE_AW'(n_eff);
  assign old_leaf = NODE_AW'(emp_rdata_q) + NODE_AW'(n_eff);
  assign q_up     = p_q >> 1;

  assign acc        = sum_q + (pend_q ? node_rdata_q : '0);
  assign leaf_sum   = node_rdata_q + delta_q;
  assign parent_sum = cur_q + node_rdata_q;
  assign r_dec      = r_q - BOUND_W'(1);

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_DATA_W'(out_cnt_q);
  assign m_axis_tuser_o  = out_err_q;

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    p_d        = p_q;
    cur_d      = cur_q;
    delta_d    = delta_q;
    second_d   = second_q;
    l_d        = l_q;
    r_d        = r_q;
    sum_d      = sum_q;
    pend_d     = pend_q;
    out_load   = 1'b0;
    out_cnt_d  = '0;
    out_err_d  = 1'b0;
    node_we    = 1'b0;
    node_waddr = p_q;
    node_wdata = '0;
    node_raddr = '0;
    emp_we     = 1'b0;
    walk_done  = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        node_we    = 1'b1;
        node_waddr = clr_q;
        clr_d      = clr_q + NODE_AW'(1);
        if (clr_q == NODE_AW'(NODE_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        priority if (req_q == REQ_QUERY) begin
          if (!lo_ok || !hi_ok || lo_q > hi_q) begin
            if (out_free) begin
              out_load  = 1'b1;
              out_err_d = !lo_ok || !hi_ok;
              state_d   = S_IDLE;
            end
          end else begin
            l_d     = BOUND_W'(lo_q) + BOUND_W'(n_eff);
            r_d     = BOUND_W'(hi_q) + BOUND_W'(1) + BOUND_W'(n_eff);
            sum_d   = '0;
            pend_d  = 1'b0;
            state_d = S_QL;
          end
        end else if (req_q == REQ_NONE || !emp_ok) begin
          state_d = S_IDLE;
        end else if (!nr_ok) begin
          if (out_free) begin
            out_load  = 1'b1;
            out_err_d = 1'b1;
            state_d   = S_IDLE;
          end
        end else if (req_q == REQ_CHANGE) begin
          state_d = S_CHG;
        end else begin
          emp_we   = 1'b1;
          p_d      = nr_leaf;
          delta_d  = DELTA_INC;
          second_d = 1'b0;
          state_d  = S_RDLEAF;
        end
      end
      S_CHG: begin
        emp_we  = 1'b1;
        state_d = S_RDLEAF;
        if (old_ok) begin
          p_d      = old_leaf;
          delta_d  = DELTA_DEC;
          second_d = 1'b1;
        end else begin
          p_d      = nr_leaf;
          delta_d  = DELTA_INC;
          second_d = 1'b0;
        end
      end
      S_RDLEAF: begin
        node_raddr = p_q;
        state_d    = S_LEAF;
      end
      S_LEAF: begin
        node_we    = 1'b1;
        node_waddr = p_q;
        node_wdata = leaf_sum;
        cur_d      = leaf_sum;
        node_raddr = p_q ^ NODE_AW'(1);
        if (p_q == NODE_AW'(1)) begin
          walk_done = 1'b1;
        end else begin
          state_d = S_UP;
        end
      end
      S_UP: begin
        node_we    = 1'b1;
        node_waddr = q_up;
        node_wdata = parent_sum;
        cur_d      = parent_sum;
        p_d        = q_up;
        node_raddr = q_up ^ NODE_AW'(1);
        if (q_up == NODE_AW'(1)) begin
          walk_done = 1'b1;
        end
      end
      S_QL: begin
        sum_d  = acc;
        pend_d = 1'b0;
        if (l_q < r_q) begin
          node_raddr = l_q[NODE_AW-1:0];
          pend_d     = l_q[0];
          l_d        = l_q + BOUND_W'(l_q[0]);
          state_d    = S_QR;
        end else if (out_free) begin
          out_load  = 1'b1;
          out_cnt_d = acc;
          state_d   = S_IDLE;
        end
      end
      S_QR: begin
        sum_d      = acc;
        node_raddr = r_dec[NODE_AW-1:0];
        pend_d     = r_q[0];
        l_d        = l_q >> 1;
        r_d        = r_q >> 1;
        state_d    = S_QL;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (walk_done) begin
      if (second_q) begin
        second_d = 1'b0;
        p_d      = nr_leaf;
        delta_d  = DELTA_INC;
        state_d  = S_RDLEAF;
      end else begin
        state_d = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      second_q     <= 1'b0;
      pend_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      leaf_count_q <= LEAF_COUNT_RST;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      second_q <= second_d;
      pend_q   <= pend_d;
      if (cfg_we_i) begin
        leaf_count_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q     <= p_d;
    cur_q   <= cur_d;
    delta_q <= delta_d;
    l_q     <= l_d;
    r_q     <= r_d;
    sum_q   <= sum_d;
    if (in_accept) begin
      req_q <= s_axis_tuser_i;
      emp_q <= s_axis_tdata_i[11:0];
      nr_q  <= s_axis_tdata_i[24:12];
      lo_q  <= s_axis_tdata_i[37:25];
      hi_q  <= s_axis_tdata_i[50:38];
    end
    if (out_load) begin
      out_cnt_q <= out_cnt_d;
      out_err_q <= out_err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    node_rdata_q <= node_mem[node_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (emp_we) begin
      emp_mem[emp_q] <= nr_q;
    end
    emp_rdata_q <= emp_mem[emp_q];
  end

endmodule

[rtl/rcst_checker.sv]
// Port-level checker for the range count segment tree, with its bind statement.
// Depends on rcst_pkg and attaches to range_count_segment_tree.
module rcst_checker
  import rcst_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  cfg_we_i,
  input logic [LC_W-1:0]       cfg_wdata_i,
  input logic                  s_axis_tvalid_i,
  input logic                  s_axis_tready_o,
  input logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  input logic [REQ_W-1:0]      s_axis_tuser_i,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic [0:0]            m_axis_tuser_o
);

  // A result item held back by the sink stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result item changed while stalled");

  // A flagged range error always reports a zero count.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> m_axis_tdata_o == '0)
    else $error("range error with non-zero count");

  // Requests are worked one at a time, so an accepted item closes the input.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input ready straight after an accepted item");

  // The padding above the count is always zero.
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[OUT_DATA_W-1:CNT_W] == '0)
    else $error("result padding bits set");

endmodule

bind range_count_segment_tree rcst_checker u_rcst_checker (.*);
